### rtl/cspl_pkg.sv
// ----------------------------------------------------------------------------
// Cubic spline package
// Shared types for the cubic spline interpolator core.
// ----------------------------------------------------------------------------
`default_nettype none

package cspl_pkg;

   typedef enum logic {
      CMD_CATMULL_ROM = 1'b0,
      CMD_HERMITE     = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

### rtl/cubic_spline_interpolator_core.sv
// ----------------------------------------------------------------------------
// Cubic spline interpolator core
// Fixed-point Catmull-Rom or Hermite evaluation of one spline component per
// request, with round-half-up and saturation of the weighted sum.
// ----------------------------------------------------------------------------
// The core takes one request in every clock cycle and never stalls: busy is
// always low. The work runs through nine register stages (input, s squared
// product, rounding, s cubed product, weights, eight point-by-weight
// products, partial sums, final round, saturation), so each result shows on
// the rsp_ ports for one cycle, marked by rsp_valid. Results come out in
// request order and the receiver must take each one in the cycle it appears.
`default_nettype none

module cubic_spline_interpolator_core
   import cspl_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_cmd,
   input  wire logic signed [DATA_WIDTH-1:0] req_pa,
   input  wire logic signed [DATA_WIDTH-1:0] req_pb,
   input  wire logic signed [DATA_WIDTH-1:0] req_pc,
   input  wire logic signed [DATA_WIDTH-1:0] req_pd,
   input  wire logic        [FRAC_BITS:0]    req_param_s,
   output logic                              rsp_valid,
   output logic signed      [DATA_WIDTH-1:0] rsp_value,
   output logic                              rsp_saturated
);

   localparam int SW  = FRAC_BITS + 1;
   localparam int WW  = FRAC_BITS + 4;
   localparam int LW  = DATA_WIDTH / 2;
   localparam int HW  = DATA_WIDTH - LW;
   localparam int PW  = HW + WW;
   localparam int QW  = LW + 1 + WW;
   localparam int ACC = DATA_WIDTH + FRAC_BITS + 6;
   localparam int RW  = ACC - FRAC_BITS - 1;

   localparam logic [SW-1:0]          ONE_S    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [2*SW-1:0]        HALF_SQ  = (2*SW)'(1) << (FRAC_BITS - 1);
   localparam logic signed [WW-1:0]   ONE_W    = WW'(1) <<< FRAC_BITS;
   localparam logic signed [ACC-1:0]  ONE_ACC  = ACC'(1) <<< FRAC_BITS;

   typedef logic [3:0][DATA_WIDTH-1:0] pts_type;

   // stage valid bits
   logic [8:0] vld_ff;

   // stage 0: input register
   cmd_type          cmd0_ff, cmd1_ff, cmd2_ff, cmd3_ff;
   pts_type          pt0_ff, pt1_ff, pt2_ff, pt3_ff, pt4_ff;
   logic [SW-1:0]    s0_ff, s1_ff, s2s_ff, s3s_ff;
   logic [SW-1:0]    s_in;

   // stage 1..3: powers of s
   logic [2*SW-1:0]  sq1_ff;
   logic [2*SW-1:0]  sq_rnd;
   logic [SW-1:0]    sq2_ff;
   logic [2*SW-1:0]  cu3_ff;
   logic [2*SW-1:0]  cu_rnd;
   logic [SW-1:0]    sq3_ff;

   // stage 4: weights
   logic signed [WW-1:0]       sx, s2x, s3x;
   logic signed [3:0][WW-1:0]  w_in;
   logic signed [3:0][WW-1:0]  w4_ff;

   // stage 5: products
   logic signed [HW-1:0]  ph_w [4];
   logic signed [LW:0]    pl_w [4];
   logic signed [PW-1:0]  prodh_in [4];
   logic signed [QW-1:0]  prodl_in [4];
   logic signed [PW-1:0]  prodh5_ff [4];
   logic signed [QW-1:0]  prodl5_ff [4];

   // stage 6..8: sums, round, saturate
   logic signed [ACC-1:0] sumh_in, suml_in, sumh6_ff, suml6_ff;
   logic signed [ACC-1:0] tot_in;
   logic signed [RW-1:0]  r_in, r7_ff;
   logic                  ovf_hi, ovf_lo;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], start};
      end
   end

   assign s_in = (req_param_s > ONE_S) ? ONE_S : req_param_s;

   always_ff @(posedge clock) begin
      cmd0_ff <= cmd_type'(req_cmd);
      pt0_ff  <= {req_pd, req_pc, req_pb, req_pa};
      s0_ff   <= s_in;

      sq1_ff  <= (2*SW)'(s0_ff) * (2*SW)'(s0_ff);
      s1_ff   <= s0_ff;
      cmd1_ff <= cmd0_ff;
      pt1_ff  <= pt0_ff;

      sq2_ff  <= sq_rnd[FRAC_BITS +: SW];
      s2s_ff  <= s1_ff;
      cmd2_ff <= cmd1_ff;
      pt2_ff  <= pt1_ff;

      cu3_ff  <= (2*SW)'(sq2_ff) * (2*SW)'(s2s_ff);
      s3s_ff  <= s2s_ff;
      cmd3_ff <= cmd2_ff;
      pt3_ff  <= pt2_ff;
      sq3_ff  <= sq2_ff;

      w4_ff   <= w_in;
      pt4_ff  <= pt3_ff;
   end

   assign sq_rnd = sq1_ff + HALF_SQ;
   assign cu_rnd = cu3_ff + HALF_SQ;

   always_comb begin
      sx  = $signed({{(WW-SW){1'b0}}, s3s_ff});
      s2x = $signed({{(WW-SW){1'b0}}, sq3_ff});
      s3x = $signed({{(WW-SW){1'b0}}, cu_rnd[FRAC_BITS +: SW]});
      unique case (cmd3_ff)
         CMD_CATMULL_ROM: begin
            w_in[0] = (s2x <<< 1) - s3x - sx;
            w_in[1] = (s3x <<< 1) + s3x - (s2x <<< 2) - s2x + (ONE_W <<< 1);
            w_in[2] = (s2x <<< 2) - (s3x <<< 1) - s3x + sx;
            w_in[3] = s3x - s2x;
         end
         CMD_HERMITE: begin
            w_in[0] = ((s3x <<< 1) - (s2x <<< 1) - s2x + ONE_W) <<< 1;
            w_in[1] = (s3x - (s2x <<< 1) + sx) <<< 1;
            w_in[2] = ((s2x <<< 1) + s2x - (s3x <<< 1)) <<< 1;
            w_in[3] = (s3x - s2x) <<< 1;
         end
         default: begin
            w_in = '0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ph_w[i]     = $signed(pt4_ff[i][DATA_WIDTH-1 -: HW]);
         pl_w[i]     = $signed({1'b0, pt4_ff[i][LW-1:0]});
         prodh_in[i] = PW'(ph_w[i]) * PW'($signed(w4_ff[i]));
         prodl_in[i] = QW'(pl_w[i]) * QW'($signed(w4_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prodh5_ff[i] <= prodh_in[i];
         prodl5_ff[i] <= prodl_in[i];
      end
      sumh6_ff <= sumh_in;
      suml6_ff <= suml_in;
      r7_ff    <= r_in;
   end

   assign sumh_in = ACC'(prodh5_ff[0]) + ACC'(prodh5_ff[1])
                  + ACC'(prodh5_ff[2]) + ACC'(prodh5_ff[3]);
   assign suml_in = ACC'(prodl5_ff[0]) + ACC'(prodl5_ff[1])
                  + ACC'(prodl5_ff[2]) + ACC'(prodl5_ff[3]);

   assign tot_in = (sumh6_ff <<< LW) + suml6_ff + ONE_ACC;
   assign r_in   = RW'(tot_in >>> (FRAC_BITS + 1));

   assign ovf_hi = !r7_ff[RW-1] && (|r7_ff[RW-2:DATA_WIDTH-1]);
   assign ovf_lo = r7_ff[RW-1] && !(&r7_ff[RW-2:DATA_WIDTH-1]);

   always_ff @(posedge clock) begin
      priority if (ovf_hi) begin
         rsp_value <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else if (ovf_lo) begin
         rsp_value <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         rsp_value <= r7_ff[DATA_WIDTH-1:0];
      end
      rsp_saturated <= ovf_hi || ovf_lo;
   end

   assign rsp_valid = vld_ff[8];

endmodule

`default_nettype wire

### tb/sv/cubic_spline_interpolator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic spline interpolator core test
// Drives Catmull-Rom and Hermite requests with directed corner values and
// random control points and parameters. Each accepted request is evaluated
// by a fixed-point model in this file, and its result is compared with the
// core's result in request order. The sender idles at random in some phases,
// and it waits for all results between phases.
// ----------------------------------------------------------------------------

module cubic_spline_interpolator_core_test;
   import cspl_pkg::*;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam longint ONE     = longint'(1) << FRAC_BITS;
   localparam longint MAX_VAL = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint MIN_VAL = -MAX_VAL - 1;
   localparam int ITEMS_PER_PHASE = 375;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 200000;

   typedef logic signed [DATA_WIDTH-1:0] point_type;
   typedef logic [FRAC_BITS:0] param_type;

   typedef struct {
      cmd_type              cmd;
      point_type            pa;
      point_type            pb;
      point_type            pc;
      point_type            pd;
      param_type            param_s;
   } spline_req_type;

   typedef struct {
      point_type value;
      logic      saturated;
   } spline_rsp_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic                req_cmd       = 1'b0;
   point_type           req_pa        = '0;
   point_type           req_pb        = '0;
   point_type           req_pc        = '0;
   point_type           req_pd        = '0;
   param_type           req_param_s   = '0;
   logic                busy;
   logic                rsp_valid;
   point_type           rsp_value;
   logic                rsp_saturated;

   spline_req_type      pending_req[$];
   spline_rsp_type      expected_rsp[$];
   int                  sender_idle_pct = 0;
   int                  error_count     = 0;
   int                  cycle_count     = 0;

   cubic_spline_interpolator_core #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_pa       (req_pa),
      .req_pb       (req_pb),
      .req_pc       (req_pc),
      .req_pd       (req_pd),
      .req_param_s  (req_param_s),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_saturated(rsp_saturated)
   );

   always #6 clock = ~clock;

   function automatic spline_rsp_type spline_eval(cmd_type cmd, point_type pa, point_type pb,
                                                  point_type pc, point_type pd,
                                                  param_type param_s);
      longint     s;
      longint     s2;
      longint     s3;
      longint     w[4];
      longint     p[4];
      longint     acc;
      longint     r;
      spline_rsp_type rsp;
      s = longint'(param_s);
      if (s > ONE) s = ONE;
      s2 = (s * s + ONE / 2) >>> FRAC_BITS;
      s3 = (s2 * s + ONE / 2) >>> FRAC_BITS;
      if (cmd == CMD_CATMULL_ROM) begin
         w[0] = -s3 + 2 * s2 - s;
         w[1] = 3 * s3 - 5 * s2 + 2 * ONE;
         w[2] = -3 * s3 + 4 * s2 + s;
         w[3] = s3 - s2;
      end else begin
         w[0] = 2 * (2 * s3 - 3 * s2 + ONE);
         w[1] = 2 * (s3 - 2 * s2 + s);
         w[2] = 2 * (-2 * s3 + 3 * s2);
         w[3] = 2 * (s3 - s2);
      end
      p[0] = longint'(pa);
      p[1] = longint'(pb);
      p[2] = longint'(pc);
      p[3] = longint'(pd);
      acc = ONE;
      for (int i = 0; i < 4; i++) acc += w[i] * p[i];
      r = acc >>> (FRAC_BITS + 1);
      rsp.saturated = 1'b0;
      if (r > MAX_VAL) begin
         r = MAX_VAL;
         rsp.saturated = 1'b1;
      end else if (r < MIN_VAL) begin
         r = MIN_VAL;
         rsp.saturated = 1'b1;
      end
      rsp.value = point_type'(r);
      return rsp;
   endfunction

   function automatic point_type rand_point();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return point_type'($urandom);
         4, 5, 6:    return point_type'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
         7:          return point_type'(MAX_VAL);
         8:          return point_type'(MIN_VAL);
         default:    return ($urandom_range(0, 1) != 0) ? point_type'(0) : point_type'(-1);
      endcase
   endfunction

   function automatic param_type rand_param();
      case ($urandom_range(0, 9))
         8: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return param_type'(1);
               2:       return param_type'(ONE - 1);
               default: return param_type'(ONE);
            endcase
         end
         9:       return param_type'($urandom_range(ONE + 1, 2 * ONE - 1));
         default: return param_type'($urandom_range(0, ONE));
      endcase
   endfunction

   task automatic queue_req(cmd_type cmd, point_type pa, point_type pb, point_type pc,
                            point_type pd, param_type param_s);
      spline_req_type req;
      req.cmd     = cmd;
      req.pa      = pa;
      req.pb      = pb;
      req.pc      = pc;
      req.pd      = pd;
      req.param_s = param_s;
      pending_req.push_back(req);
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || expected_rsp.size() != 0 || start)
         @(negedge clock);
   endtask

   // accept on start && !busy, then advance to the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(spline_eval(cmd_type'(req_cmd), req_pa, req_pb, req_pc,
                                               req_pd, req_param_s));
            void'(pending_req.pop_front());
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_req.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            start       <= 1'b1;
            req_cmd     <= pending_req[0].cmd;
            req_pa      <= pending_req[0].pa;
            req_pb      <= pending_req[0].pb;
            req_pc      <= pending_req[0].pc;
            req_pd      <= pending_req[0].pd;
            req_param_s <= pending_req[0].param_s;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      spline_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("rsp_valid with no request outstanding");
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_value);
               error_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int idle_by_phase[4];
      point_type pmax;
      point_type pmin;
      idle_by_phase = '{0, 62, 0, 34};
      pmax = point_type'(MAX_VAL);
      pmin = point_type'(MIN_VAL);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corners for both modes, then saturation and rounding cases
      for (int m = 0; m < 2; m++) begin
         cmd_type c;
         c = cmd_type'(m);
         queue_req(c, 32'sd65536, 32'sd131072, -32'sd65536, 32'sd3, '0);
         queue_req(c, 32'sd65536, 32'sd131072, -32'sd65536, 32'sd3, param_type'(ONE));
         queue_req(c, 32'sd100, -32'sd7, 32'sd99999, 32'sd1, param_type'(ONE / 2));
         queue_req(c, 32'sd5, 32'sd6, 32'sd7, 32'sd8, param_type'(2 * ONE - 1));
         queue_req(c, 32'sd1, 32'sd1, 32'sd1, 32'sd1, param_type'(1));
         queue_req(c, -32'sd1, -32'sd1, -32'sd1, -32'sd1, param_type'(ONE + 1));
         queue_req(c, pmax, pmax, pmax, pmax, param_type'(ONE / 4));
         queue_req(c, pmin, pmin, pmin, pmin, param_type'(ONE / 4));
         queue_req(c, '0, '0, '0, '0, param_type'(ONE - 1));
      end
      queue_req(CMD_CATMULL_ROM, pmin, pmax, pmax, pmin, param_type'(ONE / 2));
      queue_req(CMD_CATMULL_ROM, pmax, pmin, pmin, pmax, param_type'(ONE / 2));
      queue_req(CMD_HERMITE, pmax, pmax, pmin, pmin, param_type'(ONE / 2));
      queue_req(CMD_HERMITE, pmin, pmin, pmax, pmax, param_type'(ONE / 2));
      queue_req(CMD_CATMULL_ROM, 32'sd1, -32'sd1, 32'sd1, -32'sd1, param_type'(3));

      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         sender_idle_pct = idle_by_phase[ph];
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_req(cmd_type'($urandom_range(0, 1)), rand_point(), rand_point(),
                      rand_point(), rand_point(), rand_param());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
